>>> sv/wvi_pkg.sv
// ============================================================================
// wvi_pkg
// Shared widths, codes, types and helpers for the wavetable voice interpolator.
// ============================================================================
package wvi_pkg;

   // wave memory geometry (depth is a power of two)
   localparam int WAVE_DEPTH   = 256;
   localparam int WAVE_AW      = $clog2(WAVE_DEPTH);
   localparam int WAVE_INDEX_W = 8;
   localparam int IDX_EXT_W    = (WAVE_AW > WAVE_INDEX_W) ? WAVE_AW : WAVE_INDEX_W;

   // field widths
   localparam int WAVE_VALUE_W = 16;
   localparam int PHASE_W      = 16;
   localparam int STEP_W       = 17;
   localparam int MODE_W       = 3;
   localparam int GAIN_W       = 9;
   localparam int SAMPLE_W     = 17;
   localparam int NUM_GAINS    = 4;

   // datapath widths: interpolation terms stay well inside 24 bits
   localparam int CALC_W = 24;
   localparam int PROD_W = CALC_W + GAIN_W + 1;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 17;

   localparam logic [CSR_INDEX_W-1:0] CSR_WAVE_MASK       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_STEP      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTERP_MODE     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_MAIN_LEFT  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_MAIN_RIGHT = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_ECHO_LEFT  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_ECHO_RIGHT = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAVE_PRESENT    = 3'd7;

   // gain slots
   localparam int GAIN_MAIN_LEFT  = 0;
   localparam int GAIN_MAIN_RIGHT = 1;
   localparam int GAIN_ECHO_LEFT  = 2;
   localparam int GAIN_ECHO_RIGHT = 3;

   // interpolation modes
   localparam logic [MODE_W-1:0] MODE_NONE      = 3'd0;
   localparam logic [MODE_W-1:0] MODE_NEAREST   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_LINEAR    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_QUADRATIC = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CUBIC     = 3'd4;

   // item kinds
   localparam logic KIND_WRITE = 1'b1;

   // reset values
   localparam logic [PHASE_W-1:0]       RST_WAVE_MASK  = 16'hFFFF;
   localparam logic signed [STEP_W-1:0] RST_PHASE_STEP = 17'sh00100;
   localparam logic [MODE_W-1:0]        RST_MODE       = MODE_CUBIC;

   // rounding constants of the cubic kernel
   localparam int ROUND_8 = 'h80;
   localparam int ROUND_9 = 'h100;

   typedef struct packed {
      logic [PHASE_W-1:0]                wave_mask;
      logic signed [STEP_W-1:0]          phase_step;
      logic [MODE_W-1:0]                 interp_mode;
      logic [NUM_GAINS-1:0][GAIN_W-1:0]  gain;
      logic                              wave_present;
   } cfg_type;

   // command passed from front to back
   typedef struct packed {
      logic                              is_write;
      logic [WAVE_AW-1:0]                addr;
      logic signed [WAVE_VALUE_W-1:0]    value;
      logic [PHASE_W-1:0]                phase;
   } cmd_type;

   // word index modulo the memory depth
   function automatic logic [WAVE_AW-1:0] wave_addr(input logic [WAVE_INDEX_W-1:0] idx);
      logic [IDX_EXT_W-1:0] ext;
      ext = IDX_EXT_W'(idx);
      return ext[WAVE_AW-1:0];
   endfunction

endpackage

>>> sv/wvi_req_if.sv
// ============================================================================
// wvi_req_if
// Input channel: tick or wave-memory write items.
// ============================================================================
interface wvi_req_if;
   logic                                     valid;
   logic                                     ready;
   logic                                     kind;
   logic [wvi_pkg::WAVE_INDEX_W-1:0]         wave_index;
   logic signed [wvi_pkg::WAVE_VALUE_W-1:0]  wave_value;

   modport source(output valid, kind, wave_index, wave_value, input ready);
   modport sink(input valid, kind, wave_index, wave_value, output ready);
endinterface

>>> sv/wvi_rsp_if.sv
// ============================================================================
// wvi_rsp_if
// Result channel: interpolated sample and four gain-scaled copies.
// ============================================================================
interface wvi_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [wvi_pkg::SAMPLE_W-1:0]   sample;
   logic signed [wvi_pkg::SAMPLE_W-1:0]   main_left;
   logic signed [wvi_pkg::SAMPLE_W-1:0]   main_right;
   logic signed [wvi_pkg::SAMPLE_W-1:0]   echo_left;
   logic signed [wvi_pkg::SAMPLE_W-1:0]   echo_right;

   modport source(output valid, sample, main_left, main_right, echo_left, echo_right,
                  input ready);
   modport sink(input valid, sample, main_left, main_right, echo_left, echo_right,
                output ready);
endinterface

>>> sv/wavetable_voice_interpolator.sv
// ============================================================================
// wavetable_voice_interpolator
// One wavetable synth voice with selectable interpolation and four gain sends.
//
//   channel   direction  payload
//   req_ch    in         kind, wave_index, wave_value
//   rsp_ch    out        sample, main_left, main_right, echo_left, echo_right
//   csr_*     in         we, index, wdata (write only)
//
// A write item is done in the back end as it is popped. A tick pops the
// command, reads the memory once per tap (single read port) and waits for the
// last word to land, runs each kernel step on the shared multiplier (multiply,
// then add), forms the four gain products and loads the result register.
// Silent ticks (no wave) only advance the phase and cost no back-end time.
// Reset is synchronous; the wave memory is not cleared. A two-entry queue lets
// the front keep accepting while the back end works; a result that is not yet
// transferred holds the back end in its gain stage.
// ============================================================================
module wavetable_voice_interpolator (
   input  logic                                clock,
   input  logic                                reset,
   wvi_req_if.sink                             req_ch,
   wvi_rsp_if.source                           rsp_ch,
   input  logic                                csr_we,
   input  logic [wvi_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [wvi_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   wvi_pkg::cfg_type  cfg_ff, cfg_in;
   logic              push_valid, push_ready;
   wvi_pkg::cmd_type  push_data;
   logic              pop_valid, pop_ready;
   wvi_pkg::cmd_type  pop_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            wvi_pkg::CSR_WAVE_MASK:
               cfg_in.wave_mask = csr_wdata[wvi_pkg::PHASE_W-1:0];
            wvi_pkg::CSR_PHASE_STEP:
               cfg_in.phase_step = csr_wdata[wvi_pkg::STEP_W-1:0];
            wvi_pkg::CSR_INTERP_MODE:
               cfg_in.interp_mode = csr_wdata[wvi_pkg::MODE_W-1:0];
            wvi_pkg::CSR_GAIN_MAIN_LEFT:
               cfg_in.gain[wvi_pkg::GAIN_MAIN_LEFT] = csr_wdata[wvi_pkg::GAIN_W-1:0];
            wvi_pkg::CSR_GAIN_MAIN_RIGHT:
               cfg_in.gain[wvi_pkg::GAIN_MAIN_RIGHT] = csr_wdata[wvi_pkg::GAIN_W-1:0];
            wvi_pkg::CSR_GAIN_ECHO_LEFT:
               cfg_in.gain[wvi_pkg::GAIN_ECHO_LEFT] = csr_wdata[wvi_pkg::GAIN_W-1:0];
            wvi_pkg::CSR_GAIN_ECHO_RIGHT:
               cfg_in.gain[wvi_pkg::GAIN_ECHO_RIGHT] = csr_wdata[wvi_pkg::GAIN_W-1:0];
            wvi_pkg::CSR_WAVE_PRESENT:
               cfg_in.wave_present = csr_wdata[0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wave_mask    <= wvi_pkg::RST_WAVE_MASK;
         cfg_ff.phase_step   <= wvi_pkg::RST_PHASE_STEP;
         cfg_ff.interp_mode  <= wvi_pkg::RST_MODE;
         cfg_ff.gain         <= '0;
         cfg_ff.wave_present <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   wvi_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   wvi_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   wvi_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_ch    (rsp_ch)
   );

endmodule

>>> sv/wvi_front.sv
// ============================================================================
// wvi_front
// Accepts items, keeps the phase accumulator and queues work for the back end.
// ============================================================================
module wvi_front (
   input  logic              clock,
   input  logic              reset,
   input  wvi_pkg::cfg_type  cfg,
   wvi_req_if.sink           req_ch,
   output logic              push_valid,
   input  logic              push_ready,
   output wvi_pkg::cmd_type  push_data
);

   logic [wvi_pkg::PHASE_W-1:0] phase_ff;
   logic [wvi_pkg::PHASE_W-1:0] phase_in;
   logic                        is_write;
   logic                        accept;

   assign is_write      = (req_ch.kind == wvi_pkg::KIND_WRITE);
   assign req_ch.ready  = push_ready;
   assign accept        = req_ch.valid && push_ready;

   // silent ticks (no wave) only move the phase
   assign push_valid = req_ch.valid && (is_write || cfg.wave_present);

   assign push_data.is_write = is_write;
   assign push_data.addr     = wvi_pkg::wave_addr(req_ch.wave_index);
   assign push_data.value    = req_ch.wave_value;
   assign push_data.phase    = phase_ff;

   always_comb begin
      phase_in = phase_ff;
      if (accept && !is_write) begin
         phase_in = (phase_ff + cfg.phase_step[wvi_pkg::PHASE_W-1:0]) & cfg.wave_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

>>> sv/wvi_queue.sv
// ============================================================================
// wvi_queue
// Two-entry command queue between the front and back ends.
// ============================================================================
module wvi_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  wvi_pkg::cmd_type  push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output wvi_pkg::cmd_type  pop_data
);

   localparam int QDEPTH = 2;
   localparam int PTR_W  = $clog2(QDEPTH);
   localparam int CNT_W  = $clog2(QDEPTH + 1);

   wvi_pkg::cmd_type  entry_ff [QDEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(QDEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> sv/wvi_back.sv
// ============================================================================
// wvi_back
// Owns the wave memory: performs writes, fetches taps, runs the interpolation
// kernel on one shared multiplier, applies the gains and holds the result.
// ============================================================================
module wvi_back (
   input  logic              clock,
   input  logic              reset,
   input  wvi_pkg::cfg_type  cfg,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  wvi_pkg::cmd_type  pop_data,
   wvi_rsp_if.source         rsp_ch
);

   localparam int CALC_W   = wvi_pkg::CALC_W;
   localparam int PROD_W   = wvi_pkg::PROD_W;
   localparam int SAMPLE_W = wvi_pkg::SAMPLE_W;
   localparam int NUM_TAPS = 4;
   localparam int TAP_W    = $clog2(NUM_TAPS);
   localparam int CNT_W    = $clog2(NUM_TAPS + 1);
   localparam int GSEL_W   = $clog2(wvi_pkg::NUM_GAINS);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_ADD  = 3'd3;
   localparam logic [2:0] ST_GAIN = 3'd4;

   localparam logic [1:0] SH_7 = 2'd0;
   localparam logic [1:0] SH_8 = 2'd1;
   localparam logic [1:0] SH_9 = 2'd2;

   localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'((1 << (SAMPLE_W - 1)) - 1);
   localparam logic signed [PROD_W-1:0] SAT_LO = ~SAT_HI;

   function automatic logic signed [SAMPLE_W-1:0] sat17(input logic signed [PROD_W-1:0] v);
      logic signed [SAMPLE_W-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[SAMPLE_W-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[SAMPLE_W-1:0];
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

   // wave memory
   logic signed [wvi_pkg::WAVE_VALUE_W-1:0] mem [wvi_pkg::WAVE_DEPTH];
   logic signed [wvi_pkg::WAVE_VALUE_W-1:0] rdata_ff;
   logic                                    mem_we, mem_re;
   logic [wvi_pkg::WAVE_AW-1:0]             mem_raddr;
   logic [wvi_pkg::WAVE_INDEX_W-1:0]        tap_index;

   // control
   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [1:0]        step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_load;

   // payload
   wvi_pkg::cmd_type                          cmd_ff, cmd_in;
   logic signed [wvi_pkg::WAVE_VALUE_W-1:0]   p_ff [NUM_TAPS];
   logic signed [wvi_pkg::WAVE_VALUE_W-1:0]   p_in [NUM_TAPS];
   logic signed [CALC_W-1:0]                  t_ff, t_in;
   logic signed [PROD_W-1:0]                  prod_ff, prod_in;
   logic signed [SAMPLE_W-1:0]                sample_ff, sample_in;
   logic signed [SAMPLE_W-1:0]                gout_ff [wvi_pkg::NUM_GAINS-1];
   logic signed [SAMPLE_W-1:0]                gout_in [wvi_pkg::NUM_GAINS-1];
   logic signed [SAMPLE_W-1:0]                out_sample_ff, out_ml_ff, out_mr_ff;
   logic signed [SAMPLE_W-1:0]                out_el_ff, out_er_ff;

   // kernel step
   logic [CNT_W-1:0]              ntaps;
   logic [wvi_pkg::MODE_W-1:0]    mode;
   logic signed [CALC_W-1:0]      pe0, pe1, pe2, pe3, dif;
   logic signed [CALC_W-1:0]      step_x, step_y;
   logic signed [PROD_W-1:0]      step_rnd;
   logic [1:0]                    step_sh;
   logic                          last_step;
   logic signed [CALC_W-1:0]      mul_x;
   logic [wvi_pkg::GAIN_W-1:0]    mul_m;
   logic signed [PROD_W-1:0]      mul_out;
   logic signed [PROD_W-1:0]      rnd_sum, sh_val, add_out, gain_sh;
   logic [TAP_W-1:0]              tap_sel;
   logic [GSEL_W-1:0]             gsel;

   assign mode = cfg.interp_mode;

   always_comb begin
      unique case (mode)
         wvi_pkg::MODE_NONE:      ntaps = CNT_W'(0);
         wvi_pkg::MODE_NEAREST:   ntaps = CNT_W'(1);
         wvi_pkg::MODE_LINEAR:    ntaps = CNT_W'(2);
         wvi_pkg::MODE_QUADRATIC: ntaps = CNT_W'(3);
         wvi_pkg::MODE_CUBIC:     ntaps = CNT_W'(4);
         default:                 ntaps = CNT_W'(0);
      endcase
   end

   // tap k sits at word ((phase + k*256) & mask) >> 8
   assign tap_index = (cmd_ff.phase[wvi_pkg::PHASE_W-1:8] + wvi_pkg::WAVE_INDEX_W'(cnt_ff))
                      & cfg.wave_mask[wvi_pkg::PHASE_W-1:8];
   assign mem_raddr = wvi_pkg::wave_addr(tap_index);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[pop_data.addr] <= pop_data.value;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   assign pe0 = CALC_W'(p_ff[0]);
   assign pe1 = CALC_W'(p_ff[1]);
   assign pe2 = CALC_W'(p_ff[2]);
   assign pe3 = CALC_W'(p_ff[3]);
   assign dif = pe1 - pe2;

   // per-step operands: result = ((x * frac + rnd) >>> sh) + y
   always_comb begin
      step_x    = '0;
      step_y    = '0;
      step_rnd  = '0;
      step_sh   = SH_8;
      last_step = 1'b1;
      unique case (mode)
         wvi_pkg::MODE_LINEAR: begin
            step_x = pe1 - pe0;
            step_y = pe0;
         end
         wvi_pkg::MODE_QUADRATIC: begin
            if (step_ff == 2'd0) begin
               step_x    = ((pe0 + pe2) >>> 1) - pe1;
               step_y    = pe1 - ((pe2 + pe0 + (pe0 <<< 1)) >>> 2);
               step_sh   = SH_9;
               last_step = 1'b0;
            end else begin
               step_x  = t_ff;
               step_y  = pe0;
               step_sh = SH_7;
            end
         end
         wvi_pkg::MODE_CUBIC: begin
            if (step_ff == 2'd0) begin
               step_x    = (dif <<< 1) + dif + pe3 - pe0;
               step_rnd  = PROD_W'(wvi_pkg::ROUND_8);
               last_step = 1'b0;
            end else if (step_ff == 2'd1) begin
               step_x    = (pe0 <<< 1) - (pe1 <<< 2) - pe1 + (pe2 <<< 2) - pe3 + t_ff;
               step_rnd  = PROD_W'(wvi_pkg::ROUND_8);
               last_step = 1'b0;
            end else begin
               step_x   = pe2 - pe0 + t_ff;
               step_y   = pe1;
               step_rnd = PROD_W'(wvi_pkg::ROUND_9);
               step_sh  = SH_9;
            end
         end
         default: begin
            step_x = '0;
         end
      endcase
   end

   // shared multiplier: kernel steps use the phase fraction, gain steps the gain
   assign gsel = cnt_ff[GSEL_W-1:0];
   always_comb begin
      if (state_ff == ST_GAIN) begin
         mul_x = CALC_W'(sample_ff);
         mul_m = cfg.gain[gsel];
      end else begin
         mul_x = step_x;
         mul_m = {1'b0, cmd_ff.phase[7:0]};
      end
   end
   assign mul_out = PROD_W'(mul_x) * PROD_W'($signed({1'b0, mul_m}));

   assign rnd_sum = prod_ff + step_rnd;
   always_comb begin
      unique case (step_sh)
         SH_7:    sh_val = rnd_sum >>> 7;
         SH_8:    sh_val = rnd_sum >>> 8;
         SH_9:    sh_val = rnd_sum >>> 9;
         default: sh_val = rnd_sum >>> 8;
      endcase
   end
   assign add_out = sh_val + PROD_W'(step_y);
   assign gain_sh = prod_ff >>> 8;

   assign tap_sel = TAP_W'(cnt_ff - 1'b1);

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      step_in   = step_ff;
      cmd_in    = cmd_ff;
      p_in      = p_ff;
      t_in      = t_ff;
      prod_in   = prod_ff;
      sample_in = sample_ff;
      gout_in   = gout_ff;
      pop_ready = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               if (pop_data.is_write) begin
                  mem_we = 1'b1;
               end else begin
                  cmd_in   = pop_data;
                  cnt_in   = '0;
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            // read data arrives in the cycle after the address
            if (cnt_ff < ntaps) begin
               mem_re = 1'b1;
            end
            if (cnt_ff != '0) begin
               p_in[tap_sel] = rdata_ff;
            end
            if (cnt_ff == ntaps) begin
               step_in = '0;
               cnt_in  = '0;
               unique case (mode)
                  wvi_pkg::MODE_NEAREST: begin
                     sample_in = SAMPLE_W'(p_in[0]);
                     state_in  = ST_GAIN;
                  end
                  wvi_pkg::MODE_LINEAR, wvi_pkg::MODE_QUADRATIC, wvi_pkg::MODE_CUBIC: begin
                     state_in = ST_MUL;
                  end
                  default: begin
                     sample_in = '0;
                     state_in  = ST_GAIN;
                  end
               endcase
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_MUL: begin
            prod_in  = mul_out;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            t_in = CALC_W'(add_out);
            if (last_step) begin
               sample_in = sat17(add_out);
               cnt_in    = '0;
               state_in  = ST_GAIN;
            end else begin
               step_in  = step_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_GAIN: begin
            // one product per cycle, scaled and saturated in the next
            if (cnt_ff < CNT_W'(wvi_pkg::NUM_GAINS)) begin
               prod_in = mul_out;
               cnt_in  = cnt_ff + 1'b1;
               if (cnt_ff != '0) begin
                  gout_in[tap_sel] = sat17(gain_sh);
               end
            end else if (!rsp_valid_ff || rsp_ch.ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      step_ff   <= step_in;
      cmd_ff    <= cmd_in;
      p_ff      <= p_in;
      t_ff      <= t_in;
      prod_ff   <= prod_in;
      sample_ff <= sample_in;
      gout_ff   <= gout_in;
      if (out_load) begin
         out_sample_ff <= sample_ff;
         out_ml_ff     <= gout_ff[wvi_pkg::GAIN_MAIN_LEFT];
         out_mr_ff     <= gout_ff[wvi_pkg::GAIN_MAIN_RIGHT];
         out_el_ff     <= gout_ff[wvi_pkg::GAIN_ECHO_LEFT];
         out_er_ff     <= sat17(gain_sh);
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.sample     = out_sample_ff;
   assign rsp_ch.main_left  = out_ml_ff;
   assign rsp_ch.main_right = out_mr_ff;
   assign rsp_ch.echo_left  = out_el_ff;
   assign rsp_ch.echo_right = out_er_ff;

endmodule

>>> sim/wavetable_voice_interpolator_tb.sv
// ----------------------------------------------------------------------------
// wavetable_voice_interpolator_tb
// Self-checking bench for the wavetable voice. The bench keeps its own model of
// the voice: phase, wave memory and register settings. Each accepted tick with
// a wave present yields an expected sample and four gain products; results are
// checked field by field, in order. A short directed pass covers reset values,
// every mode and the wrap and silent cases. Random traffic follows, with random
// register settings between segments and three source/sink idle patterns.
// ----------------------------------------------------------------------------
module wavetable_voice_interpolator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wvi_pkg::*;

   localparam logic   KIND_TICK  = ~KIND_WRITE;
   localparam longint S17_MAX    = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
   localparam longint S17_MIN    = -(longint'(1) <<< (SAMPLE_W - 1));
   localparam int     DRAIN_WAIT = 64;   // back end can hold writes behind a tick

   // index 0 is the sample, index 1 + gain slot is that gain product
   typedef logic [NUM_GAINS:0][SAMPLE_W-1:0] voice_out_t;

   logic                    clock;
   logic                    reset;
   logic                    csr_we;
   logic [CSR_INDEX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   wvi_req_if req_ch();
   wvi_rsp_if rsp_ch();

   wavetable_voice_interpolator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // voice model
   cfg_type                         voice_cfg;
   logic [PHASE_W-1:0]              voice_phase;
   logic signed [WAVE_VALUE_W-1:0]  word_mem [WAVE_DEPTH];
   bit                              word_written [WAVE_DEPTH];
   voice_out_t                      expected_voice_q [$];

   int send_idle_pct;
   int rsp_stall_pct;
   int fail_count;
   int items_sent;
   int writes_sent;
   int results_seen;
   int configs_applied;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("tb: failure");
      $finish;
   end

   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // ---------------------------------------------------------------- model

   function automatic longint clamp17(input longint v);
      if (v > S17_MAX) return S17_MAX;
      if (v < S17_MIN) return S17_MIN;
      return v;
   endfunction

   function automatic logic [WAVE_AW-1:0] tap_addr(input int k);
      logic [PHASE_W-1:0] a;
      a = (voice_phase + (PHASE_W'(k) << 8)) & voice_cfg.wave_mask;
      return WAVE_AW'(a >> 8);
   endfunction

   function automatic longint tap_word(input int k);
      return longint'(word_mem[tap_addr(k)]);
   endfunction

   function automatic int taps_for_mode(input logic [MODE_W-1:0] mode);
      case (mode)
         MODE_NEAREST:   return 1;
         MODE_LINEAR:    return 2;
         MODE_QUADRATIC: return 3;
         MODE_CUBIC:     return 4;
         default:        return 0;
      endcase
   endfunction

   function automatic longint interp_sample();
      longint f, p0, p1, p2, p3, t, g;
      f  = longint'(voice_phase[7:0]);
      p0 = tap_word(0);
      p1 = tap_word(1);
      p2 = tap_word(2);
      p3 = tap_word(3);
      case (voice_cfg.interp_mode)
         MODE_NEAREST: return p0;
         MODE_LINEAR:  return p0 + (((p1 - p0) * f) >>> 8);
         MODE_QUADRATIC: begin
            g = f * 128;
            t = (((((p0 + p2) >>> 1) - p1) * g) >>> 16) + p1 - ((p2 + p0 + p0 * 2) >>> 2);
            return ((t * g) >>> 14) + p0;
         end
         MODE_CUBIC: begin
            t = ((f * (3 * (p1 - p2) + p3 - p0)) + ROUND_8) >>> 8;
            t = ((f * (2 * p0 - 5 * p1 + 4 * p2 - p3 + t)) + ROUND_8) >>> 8;
            return p1 + (((f * (p2 - p0 + t)) + ROUND_9) >>> 9);
         end
         default: return 0;   // none and the unused codes emit silence
      endcase
   endfunction

   function automatic void predict_item(input logic kind,
                                        input logic [WAVE_INDEX_W-1:0] idx,
                                        input logic signed [WAVE_VALUE_W-1:0] val);
      longint     s, p;
      voice_out_t r;
      if (kind == KIND_WRITE) begin
         word_mem[WAVE_AW'(idx)]     = val;
         word_written[WAVE_AW'(idx)] = 1'b1;
         writes_sent++;
         return;
      end
      if (voice_cfg.wave_present) begin
         s    = clamp17(interp_sample());
         r[0] = s[SAMPLE_W-1:0];
         for (int g = 0; g < NUM_GAINS; g++) begin
            p      = clamp17((s * longint'(voice_cfg.gain[g])) >>> 8);
            r[g+1] = p[SAMPLE_W-1:0];
         end
         expected_voice_q.push_back(r);
      end
      voice_phase = (voice_phase + voice_cfg.phase_step[PHASE_W-1:0]) & voice_cfg.wave_mask;
   endfunction

   // -------------------------------------------------------------- checking

   function automatic string field_label(input int i);
      case (i)
         0:                   return "sample";
         1 + GAIN_MAIN_LEFT:  return "main_left";
         1 + GAIN_MAIN_RIGHT: return "main_right";
         1 + GAIN_ECHO_LEFT:  return "echo_left";
         default:             return "echo_right";
      endcase
   endfunction

   function automatic void note_failure(input string msg);
      if (fail_count < 10)
         $display("ERROR at %0t: %s", $time, msg);
      fail_count++;
   endfunction

   always @(posedge clock) begin : check_results
      voice_out_t got, want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = {rsp_ch.echo_right, rsp_ch.echo_left, rsp_ch.main_right,
                rsp_ch.main_left, rsp_ch.sample};
         results_seen++;
         if (expected_voice_q.size() == 0) begin
            note_failure($sformatf("result %0d with nothing expected, sample %0d",
                                   results_seen, $signed(got[0])));
         end else begin
            want = expected_voice_q.pop_front();
            for (int i = 0; i <= NUM_GAINS; i++)
               if (got[i] !== want[i])
                  note_failure($sformatf("result %0d %s: expected %0d, got %0d",
                                         results_seen, field_label(i),
                                         $signed(want[i]), $signed(got[i])));
         end
      end
   end

   // -------------------------------------------------------------- stimulus

   function automatic logic signed [WAVE_VALUE_W-1:0] rand_word();
      case ($urandom_range(19))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'sh0000;
         default: return WAVE_VALUE_W'($urandom);
      endcase
   endfunction

   function automatic logic [GAIN_W-1:0] rand_gain();
      case ($urandom_range(9))
         0:       return '0;
         1:       return GAIN_W'(256);
         2:       return GAIN_W'($urandom_range(257, 511));
         default: return GAIN_W'($urandom_range(0, 256));
      endcase
   endfunction

   function automatic cfg_type rand_config();
      cfg_type c;
      case ($urandom_range(9))
         0, 1, 2, 3, 4: c.wave_mask = PHASE_W'((32'd256 << $urandom_range(0, 8)) - 1);
         5, 6:          c.wave_mask = PHASE_W'($urandom);
         7:             c.wave_mask = '0;
         8:             c.wave_mask = '1;
         default:       c.wave_mask = PHASE_W'($urandom_range(1, 256) * 256 - 1);
      endcase
      case ($urandom_range(11))
         0, 1, 2, 3: c.phase_step = STEP_W'($urandom_range(1, 1023));
         4, 5:       c.phase_step = STEP_W'(-int'($urandom_range(1, 1023)));
         6, 7:       c.phase_step = STEP_W'($urandom);
         8:          c.phase_step = 17'sh0FFFF;
         9:          c.phase_step = 17'sh10000;
         10:         c.phase_step = 17'sh10001;
         default:    c.phase_step = '0;
      endcase
      if ($urandom_range(9) < 8)
         c.interp_mode = MODE_W'($urandom_range(MODE_NEAREST, MODE_CUBIC));
      else
         c.interp_mode = MODE_W'($urandom);
      for (int g = 0; g < NUM_GAINS; g++)
         c.gain[g] = rand_gain();
      c.wave_present = ($urandom_range(99) < 88);
      return c;
   endfunction

   // one transfer on the input channel; valid is left high for back-to-back items
   task automatic send_item(input logic kind, input logic [WAVE_INDEX_W-1:0] idx,
                            input logic signed [WAVE_VALUE_W-1:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.kind       <= kind;
      req_ch.wave_index <= idx;
      req_ch.wave_value <= val;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      items_sent++;
      predict_item(kind, idx, val);
   endtask

   // loads any word the next tick would read that has never been written
   task automatic send_tick();
      logic [WAVE_AW-1:0] a;
      if (voice_cfg.wave_present)
         for (int k = 0; k < taps_for_mode(voice_cfg.interp_mode); k++) begin
            a = tap_addr(k);
            if (!word_written[a])
               send_item(KIND_WRITE, WAVE_INDEX_W'(a), rand_word());
         end
      send_item(KIND_TICK, WAVE_INDEX_W'($urandom), WAVE_VALUE_W'($urandom));
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (expected_voice_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic apply_config(input cfg_type c);
      csr_write(CSR_WAVE_MASK,       CSR_DATA_W'(c.wave_mask));
      csr_write(CSR_PHASE_STEP,      CSR_DATA_W'(c.phase_step));
      csr_write(CSR_INTERP_MODE,     CSR_DATA_W'(c.interp_mode));
      csr_write(CSR_GAIN_MAIN_LEFT,  CSR_DATA_W'(c.gain[GAIN_MAIN_LEFT]));
      csr_write(CSR_GAIN_MAIN_RIGHT, CSR_DATA_W'(c.gain[GAIN_MAIN_RIGHT]));
      csr_write(CSR_GAIN_ECHO_LEFT,  CSR_DATA_W'(c.gain[GAIN_ECHO_LEFT]));
      csr_write(CSR_GAIN_ECHO_RIGHT, CSR_DATA_W'(c.gain[GAIN_ECHO_RIGHT]));
      csr_write(CSR_WAVE_PRESENT,    CSR_DATA_W'(c.wave_present));
      csr_we    <= 1'b0;
      voice_cfg  = c;
      configs_applied++;
   endtask

   // ----------------------------------------------------------------- tests

   // reset settings: cubic, full mask, unit step, all gains zero
   task automatic test_reset_state();
      send_item(KIND_WRITE, 8'd0, 16'sh7FFF);
      send_item(KIND_WRITE, 8'd1, 16'sh8000);
      send_item(KIND_WRITE, 8'd2, 16'sh7FFF);
      send_item(KIND_WRITE, 8'd3, 16'sh8000);
      send_tick();
   endtask

   // every mode code on a four-word wave of alternating extremes
   task automatic test_interp_modes();
      cfg_type c;
      c.wave_mask              = 16'h03FF;
      c.phase_step             = 17'sh00155;
      c.gain[GAIN_MAIN_LEFT]   = GAIN_W'(256);
      c.gain[GAIN_MAIN_RIGHT]  = GAIN_W'(511);
      c.gain[GAIN_ECHO_LEFT]   = GAIN_W'(128);
      c.gain[GAIN_ECHO_RIGHT]  = '0;
      c.wave_present           = 1'b1;
      for (int m = 0; m < 2 ** MODE_W; m++) begin
         c.interp_mode = MODE_W'(m);
         wait_idle();
         apply_config(c);
         send_tick();
         send_tick();
      end
   endtask

   // silent ticks still move the phase; step and mask extremes
   task automatic test_silent_and_wrap();
      cfg_type c;
      c = voice_cfg;
      c.interp_mode  = MODE_CUBIC;
      c.wave_present = 1'b0;
      wait_idle();
      apply_config(c);
      send_tick();
      send_tick();
      c.wave_present = 1'b1;
      wait_idle();
      apply_config(c);
      send_tick();
      c.wave_mask  = '0;
      c.phase_step = 17'sh10000;
      wait_idle();
      apply_config(c);
      send_tick();
      c.wave_mask   = '1;
      c.phase_step  = 17'sh0FFFF;
      c.interp_mode = MODE_LINEAR;
      for (int g = 0; g < NUM_GAINS; g++)
         c.gain[g] = '1;
      wait_idle();
      apply_config(c);
      send_tick();
      send_tick();
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input int n_items);
      int first_item;
      int seg_len;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      first_item    = items_sent;
      while (items_sent - first_item < n_items) begin
         wait_idle();
         apply_config(rand_config());
         seg_len = $urandom_range(15, 60);
         repeat (seg_len) begin
            if ($urandom_range(99) < 15)
               send_item(KIND_WRITE, WAVE_INDEX_W'($urandom), rand_word());
            else
               send_tick();
         end
      end
   endtask

   initial begin
      req_ch.valid      <= 1'b0;
      req_ch.kind       <= KIND_TICK;
      req_ch.wave_index <= '0;
      req_ch.wave_value <= '0;
      csr_we            <= 1'b0;
      csr_index         <= CSR_WAVE_MASK;
      csr_wdata         <= '0;
      reset             <= 1'b1;

      voice_cfg.wave_mask    = RST_WAVE_MASK;
      voice_cfg.phase_step   = RST_PHASE_STEP;
      voice_cfg.interp_mode  = RST_MODE;
      voice_cfg.gain         = '0;
      voice_cfg.wave_present = 1'b1;
      voice_phase            = '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_interp_modes();
      test_silent_and_wrap();
      test_random_traffic(12, 78, 400);
      test_random_traffic(78, 12, 400);
      test_random_traffic(0, 0, 400);
      wait_idle();

      $display("summary: %0d items sent (%0d wave writes, %0d ticks), %0d results checked",
               items_sent, writes_sent, items_sent - writes_sent, results_seen);
      $display("summary: %0d register settings applied, %0d mismatches",
               configs_applied, fail_count);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
